FILE: hw/rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared sizes and types for the double selection sort unit.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_ITEMS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [CNT_W-1:0]              count_t;

endpackage

FILE: hw/rtl/dss_if.sv
// ----------------------------------------------------------------------------
// dss_if
// Valid/ready channels of the sort unit: input words, result words, config.
// ----------------------------------------------------------------------------
interface dss_in_if
    import dss_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;
    logic   final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface dss_out_if
    import dss_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   end_of_run;
    logic   dropped;

    modport source (output valid, output sorted_value, output end_of_run,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input dropped, output ready);
endinterface

interface dss_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/double_selection_sort_unit.sv
// ----------------------------------------------------------------------------
// double_selection_sort_unit
// Collects a set of signed words, sorts it double-ended, streams it back out.
// ----------------------------------------------------------------------------
// Usage:
//   items   - input words (value, final_item). Words are stored one per cycle
//             while the unit is loading; the word with final_item set closes
//             the set. Words beyond MAX_ITEMS are discarded and every result
//             word of that set carries dropped = 1.
//   results - sorted words (sorted_value, end_of_run, dropped), one per stored
//             word, in ascending order or descending when cfg.data is 1.
//             end_of_run marks the last word of the set.
//   cfg     - one-bit order register, always ready; write it only while idle.
// Sequence:
//   Sorting runs floor(n/2) passes over the element RAM; a pass over the
//   unsorted words scans them with one RAM read per cycle (registered read
//   data), then makes four writes (S_WLO, S_WHEAD, S_WHI, S_WTAIL) for the
//   two exchanges, since the RAM has a single write port. Emitting reads
//   each word, then loads it into the output register.
// Reset: fill count, overflow flag, order bit and output valid clear; RAM
//   contents are not cleared and only entries of the current set are read.
// Stall: a stalled result word holds in the output register and the emit
//   sequencer waits; items is not ready until the last word of the set has
//   been loaded into the output register.
// ----------------------------------------------------------------------------
module double_selection_sort_unit
    import dss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dss_in_if.sink    items,
    dss_out_if.source results,
    dss_cfg_if.sink   cfg
);

    typedef enum logic [7:0] {
        S_LOAD    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_WLO     = 8'b0000_0100,
        S_WHEAD   = 8'b0000_1000,
        S_WHI     = 8'b0001_0000,
        S_WTAIL   = 8'b0010_0000,
        S_EMIT_RD = 8'b0100_0000,
        S_EMIT_WR = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    count_t fill_reg, fill_next;
    logic   ovf_reg, ovf_next;
    logic   desc_reg;
    addr_t  lo_reg, lo_next;
    addr_t  hi_reg, hi_next;
    addr_t  ri_reg, ri_next;
    logic   issue_done_reg, issue_done_next;
    addr_t  pi_reg, pi_next;
    logic   pv_reg, pv_next;
    addr_t  mn_reg, mn_next;
    addr_t  mx_reg, mx_next;
    addr_t  e_idx_reg, e_idx_next;
    logic   out_valid_reg, out_valid_next;

    // payload registers
    value_t mnv_reg, mnv_next;
    value_t mxv_reg, mxv_next;
    value_t lov_reg, lov_next;
    value_t hiv_reg, hiv_next;
    value_t out_value_reg, out_value_next;
    logic   out_end_reg, out_end_next;
    logic   out_drop_reg, out_drop_next;

    // element RAM
    logic   ram_we;
    addr_t  ram_waddr;
    value_t ram_wdata;
    logic   ram_re;
    addr_t  ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    value_t rd_val;

    dss_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val = value_t'(ram_rdata);

    // handshakes
    logic in_acc;
    logic out_free;
    logic store_full;
    count_t count_after;
    logic last_emit;

    assign items.ready   = (state_reg == S_LOAD);
    assign cfg.ready     = 1'b1;
    assign in_acc        = items.valid && items.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign store_full    = (fill_reg == count_t'(MAX_ITEMS));
    assign count_after   = store_full ? fill_reg : fill_reg + count_t'(1);
    assign last_emit     = (count_t'(e_idx_reg) == fill_reg - count_t'(1));

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.end_of_run   = out_end_reg;
    assign results.dropped      = out_drop_reg;

    // exchange operands: head goes to lo, tail goes to hi
    addr_t  head_idx, tail0_idx, tail_idx;
    value_t head_val, tail0_val, tail_val, hi_val;
    logic   tail_is_lo;

    assign head_idx   = desc_reg ? mx_reg  : mn_reg;
    assign head_val   = desc_reg ? mxv_reg : mnv_reg;
    assign tail0_idx  = desc_reg ? mn_reg  : mx_reg;
    assign tail0_val  = desc_reg ? mnv_reg : mxv_reg;
    // tail at lo has moved to head's slot in the first exchange
    assign tail_is_lo = (tail0_idx == lo_reg);
    assign tail_idx   = tail_is_lo ? head_idx : tail0_idx;
    assign tail_val   = tail_is_lo ? lov_reg  : tail0_val;
    // hi may have received the old lo word in the first exchange
    assign hi_val     = (head_idx == hi_reg) ? lov_reg : hiv_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ri_next         = ri_reg;
        issue_done_next = issue_done_reg;
        pi_next         = pi_reg;
        pv_next         = 1'b0;
        mn_next         = mn_reg;
        mx_next         = mx_reg;
        e_idx_next      = e_idx_reg;
        mnv_next        = mnv_reg;
        mxv_next        = mxv_reg;
        lov_next        = lov_reg;
        hiv_next        = hiv_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_end_next    = out_end_reg;
        out_drop_next   = out_drop_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[ADDR_W-1:0];
        ram_wdata       = items.value;
        ram_re          = 1'b0;
        ram_raddr       = ri_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + count_t'(1);
                    end
                    if (items.final_item)
                    begin
                        lo_next         = '0;
                        hi_next         = addr_t'(count_after - count_t'(1));
                        ri_next         = '0;
                        issue_done_next = 1'b0;
                        e_idx_next      = '0;
                        if (count_after >= count_t'(2))
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle from lo up to hi
                if (!issue_done_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ri_reg;
                    pi_next   = ri_reg;
                    pv_next   = 1'b1;
                    if (ri_reg == hi_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        ri_next = ri_reg + addr_t'(1);
                    end
                end
                // track minimum and maximum on returned data
                if (pv_reg)
                begin
                    if (pi_reg == lo_reg)
                    begin
                        mn_next  = lo_reg;
                        mx_next  = lo_reg;
                        mnv_next = rd_val;
                        mxv_next = rd_val;
                        lov_next = rd_val;
                    end
                    else if (rd_val > mxv_reg)
                    begin
                        mx_next  = pi_reg;
                        mxv_next = rd_val;
                    end
                    else if (rd_val < mnv_reg)
                    begin
                        mn_next  = pi_reg;
                        mnv_next = rd_val;
                    end
                    if (pi_reg == hi_reg)
                    begin
                        hiv_next   = rd_val;
                        state_next = S_WLO;
                    end
                end
            end

            S_WLO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = head_val;
                state_next = S_WHEAD;
            end

            S_WHEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_idx;
                ram_wdata  = lov_reg;
                state_next = S_WHI;
            end

            S_WHI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = tail_val;
                state_next = S_WTAIL;
            end

            S_WTAIL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tail_idx;
                ram_wdata  = hi_val;
                // narrow the unsorted middle
                lo_next    = lo_reg + addr_t'(1);
                hi_next    = hi_reg - addr_t'(1);
                if ((lo_reg + addr_t'(1)) < (hi_reg - addr_t'(1)))
                begin
                    ri_next         = lo_reg + addr_t'(1);
                    issue_done_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    e_idx_next = '0;
                    state_next = S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = e_idx_reg;
                state_next = S_EMIT_WR;
            end

            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_val;
                    out_end_next   = last_emit;
                    out_drop_next  = ovf_reg;
                    if (last_emit)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        e_idx_next = e_idx_reg + addr_t'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            desc_reg       <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            ri_reg         <= '0;
            issue_done_reg <= 1'b1;
            pi_reg         <= '0;
            pv_reg         <= 1'b0;
            mn_reg         <= '0;
            mx_reg         <= '0;
            e_idx_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
            if (cfg.valid && cfg.ready)
            begin
                desc_reg <= cfg.data;
            end
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            ri_reg         <= ri_next;
            issue_done_reg <= issue_done_next;
            pi_reg         <= pi_next;
            pv_reg         <= pv_next;
            mn_reg         <= mn_next;
            mx_reg         <= mx_next;
            e_idx_reg      <= e_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mnv_reg       <= mnv_next;
        mxv_reg       <= mxv_next;
        lov_reg       <= lov_next;
        hiv_reg       <= hiv_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
        out_drop_reg  <= out_drop_next;
    end

`ifndef SYNTHESIS
    // a scan only runs over a middle of at least two words
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (lo_reg < hi_reg))
        else $error("scan with empty middle");

    // the fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= count_t'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // exchange indices stay inside the unsorted middle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WLO) |->
        (mn_reg >= lo_reg && mn_reg <= hi_reg && mx_reg >= lo_reg && mx_reg <= hi_reg))
        else $error("exchange index outside middle");

    // emit load always follows a RAM read of the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_EMIT_WR) |-> ($past(state_reg) == S_EMIT_RD))
        else $error("emit without read");
`endif

endmodule
